[design/gaprc_pkg.sv]
// Shared constants and types for the population rank and crossover block.
package gaprc_pkg;

    // Fixed field widths
    localparam int FIT_W      = 32;
    localparam int SLOT_W     = 4;
    localparam int RANK_W     = 4;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int GENE_WORDS = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POP_COUNT   = 1'b0,
        CFG_ELITE_COUNT = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] POP_RESET   = 5'd10;
    localparam logic [CFG_W-1:0] ELITE_RESET = 5'd2;

    // Bank handback from the emit side to the load side
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

endpackage

[design/gaprc_in_if.sv]
// Input channel: one individual (score and gene words) per transfer.
interface gaprc_in_if #(
    parameter int GENE_BITS = 32
) ();
    import gaprc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [FIT_W-1:0] fitness;
    logic [GENE_BITS-1:0]    gene_a;
    logic [GENE_BITS-1:0]    gene_b;
    logic [GENE_BITS-1:0]    gene_c;
    logic [GENE_BITS-1:0]    gene_d;

    modport source (output valid, fitness, gene_a, gene_b, gene_c, gene_d, input ready);
    modport sink   (input valid, fitness, gene_a, gene_b, gene_c, gene_d, output ready);
endinterface

[design/gaprc_out_if.sv]
// Output channel: one next-generation individual per transfer.
interface gaprc_out_if #(
    parameter int GENE_BITS = 32
) ();
    import gaprc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SLOT_W-1:0]    slot;
    logic [GENE_BITS-1:0] child_a;
    logic [GENE_BITS-1:0] child_b;
    logic [GENE_BITS-1:0] child_c;
    logic [GENE_BITS-1:0] child_d;
    logic [RANK_W-1:0]    head_parent_rank;
    logic [RANK_W-1:0]    tail_parent_rank;
    logic                 final_slot;

    modport source (output valid, slot, child_a, child_b, child_c, child_d,
                    head_parent_rank, tail_parent_rank, final_slot, input ready);
    modport sink   (input valid, slot, child_a, child_b, child_c, child_d,
                    head_parent_rank, tail_parent_rank, final_slot, output ready);
endinterface

[design/gaprc_front.sv]
// Load side: stores gene words, keeps a sorted row of scores, posts finished batches.
module gaprc_front #(
    parameter int MAX_POP   = 16,
    parameter int GENE_BITS = 32,
    localparam int IDX_W    = $clog2(MAX_POP),
    localparam int CNT_W    = $clog2(MAX_POP + 1),
    localparam int ORD_W    = MAX_POP * IDX_W,
    localparam int JOB_W    = ORD_W + 3 * CNT_W + 1,
    localparam int ROW_W    = gaprc_pkg::GENE_WORDS * GENE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gaprc_in_if.sink              i_item,
    input  logic [CNT_W-1:0]      i_pop,
    input  logic [CNT_W-1:0]      i_elite,
    output logic                  o_gene_we,
    output logic [IDX_W:0]        o_gene_addr,
    output logic [ROW_W-1:0]      o_gene_data,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [JOB_W-1:0]      o_push_data,
    input  gaprc_pkg::t_bank_rel  i_rel
);
    import gaprc_pkg::*;

    logic signed [FIT_W-1:0] r_cell_fit [MAX_POP];
    logic signed [FIT_W-1:0] n_cell_fit [MAX_POP];
    logic [IDX_W-1:0]        r_cell_idx [MAX_POP];
    logic [IDX_W-1:0]        n_cell_idx [MAX_POP];
    logic [MAX_POP-1:0]      w_ge;
    logic [CNT_W-1:0]        r_load_cnt;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic                    r_bank;
    logic [1:0]              r_bank_busy;
    logic                    w_accept;
    logic                    w_last;
    logic [JOB_W-1:0]        w_job;

    // Take an item only while its bank is free and the batch queue has room
    assign i_item.ready = !r_bank_busy[r_bank] && i_push_ready;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_cnt_inc    = r_load_cnt + CNT_W'(1);
    assign w_last       = (w_cnt_inc >= i_pop);

    // Gene words go straight into the bank being loaded
    assign o_gene_we   = w_accept;
    assign o_gene_addr = {r_bank, r_load_cnt[IDX_W-1:0]};
    assign o_gene_data = {i_item.gene_d, i_item.gene_c, i_item.gene_b, i_item.gene_a};

    // Insert the new score behind every stored score that is greater or equal
    always_comb begin
        for (int j = 0; j < MAX_POP; j++) begin
            w_ge[j] = (CNT_W'(j) < r_load_cnt) && (r_cell_fit[j] >= i_item.fitness);
        end
        if (w_ge[0]) begin
            n_cell_fit[0] = r_cell_fit[0];
            n_cell_idx[0] = r_cell_idx[0];
        end else begin
            n_cell_fit[0] = i_item.fitness;
            n_cell_idx[0] = r_load_cnt[IDX_W-1:0];
        end
        for (int j = 1; j < MAX_POP; j++) begin
            if (w_ge[j]) begin
                n_cell_fit[j] = r_cell_fit[j];
                n_cell_idx[j] = r_cell_idx[j];
            end else if (w_ge[j-1]) begin
                n_cell_fit[j] = i_item.fitness;
                n_cell_idx[j] = r_load_cnt[IDX_W-1:0];
            end else begin
                n_cell_fit[j] = r_cell_fit[j-1];
                n_cell_idx[j] = r_cell_idx[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell_fit <= n_cell_fit;
            r_cell_idx <= n_cell_idx;
        end
    end

    // Pack the finished batch: sorted load order, loaded count, size, elite, bank
    always_comb begin
        w_job = '0;
        for (int j = 0; j < MAX_POP; j++) begin
            w_job[j*IDX_W +: IDX_W] = n_cell_idx[j];
        end
        w_job[ORD_W +: CNT_W]             = w_cnt_inc;
        w_job[ORD_W + CNT_W +: CNT_W]     = i_pop;
        w_job[ORD_W + 2 * CNT_W +: CNT_W] = i_elite;
        w_job[JOB_W-1]                    = r_bank;
    end

    assign o_push_valid = w_accept && w_last;
    assign o_push_data  = w_job;

    // Count loads, swap banks on each finished batch, free banks as they drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt  <= '0;
            r_bank      <= 1'b0;
            r_bank_busy <= '0;
        end else begin
            if (i_rel.valid) begin
                r_bank_busy[i_rel.bank] <= 1'b0;
            end
            if (w_accept) begin
                if (w_last) begin
                    r_load_cnt          <= '0;
                    r_bank              <= ~r_bank;
                    r_bank_busy[r_bank] <= 1'b1;
                end else begin
                    r_load_cnt <= w_cnt_inc;
                end
            end
        end
    end

endmodule

[design/gaprc_queue.sv]
// Small register queue of finished batches between the load and emit sides.
module gaprc_queue #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    import gaprc_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[design/gaprc_back.sv]
// Emit side: builds the rank table for a batch, then streams the next generation.
module gaprc_back #(
    parameter int MAX_POP   = 16,
    parameter int GENE_BITS = 32,
    localparam int IDX_W    = $clog2(MAX_POP),
    localparam int CNT_W    = $clog2(MAX_POP + 1),
    localparam int ORD_W    = MAX_POP * IDX_W,
    localparam int JOB_W    = ORD_W + 3 * CNT_W + 1,
    localparam int ROW_W    = gaprc_pkg::GENE_WORDS * GENE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_gene_we,
    input  logic [IDX_W:0]        i_gene_addr,
    input  logic [ROW_W-1:0]      i_gene_data,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  logic [JOB_W-1:0]      i_pop_data,
    gaprc_out_if.source           o_result,
    output gaprc_pkg::t_bank_rel  o_rel
);
    import gaprc_pkg::*;

    localparam int GENE_DEPTH = 2 * (1 << IDX_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Memories
    logic [ROW_W-1:0] r_gene_mem [GENE_DEPTH];
    logic [IDX_W-1:0] r_rank_mem [MAX_POP];

    // Sequencer
    t_state           r_state;
    logic [IDX_W-1:0] r_ord [MAX_POP];
    logic [CNT_W-1:0] r_scan_left;
    logic [CNT_W-1:0] r_wr;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_elite;
    logic             r_bank;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_head;
    logic [CNT_W-1:0] r_tail;

    logic             w_keep;
    logic             w_stall;
    logic             w_elite_slot;
    logic [CNT_W-1:0] w_hp;
    logic [CNT_W-1:0] w_tp;
    logic             w_last_slot;
    logic [CNT_W:0]   w_head_sum;

    // Stage A: rank table read
    logic             r_a_valid;
    logic [IDX_W-1:0] r_a_src_h;
    logic [IDX_W-1:0] r_a_src_t;
    logic [CNT_W-1:0] r_a_k;
    logic [CNT_W-1:0] r_a_hp;
    logic [CNT_W-1:0] r_a_tp;
    logic             r_a_last;
    logic             r_a_bank;

    // Stage B: gene read
    logic             r_b_valid;
    logic [ROW_W-1:0] r_b_head_row;
    logic [ROW_W-1:0] r_b_tail_row;
    logic [CNT_W-1:0] r_b_k;
    logic [CNT_W-1:0] r_b_hp;
    logic [CNT_W-1:0] r_b_tp;
    logic             r_b_last;
    logic             r_b_bank;

    // Output register
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [GENE_BITS-1:0] r_out_a;
    logic [GENE_BITS-1:0] r_out_b;
    logic [GENE_BITS-1:0] r_out_c;
    logic [GENE_BITS-1:0] r_out_d;
    logic [RANK_W-1:0]    r_out_hp;
    logic [RANK_W-1:0]    r_out_tp;
    logic                 r_out_last;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign w_keep      = (CNT_W'(r_ord[0]) < r_n);
    assign w_stall     = r_out_valid && !o_result.ready;

    // Parent selection for the slot being issued
    assign w_elite_slot = (r_k < r_elite);
    assign w_hp         = w_elite_slot ? r_k : r_head;
    assign w_tp         = w_elite_slot ? r_k : r_tail;
    assign w_last_slot  = (r_k == r_n - CNT_W'(1));
    assign w_head_sum   = {1'b0, r_head} + (CNT_W + 1)'(2);

    // Sequencer: take a batch, filter the sorted order into the rank table, issue slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_left <= '0;
            r_wr        <= '0;
            r_k         <= '0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        for (int j = 0; j < MAX_POP; j++) begin
                            r_ord[j] <= i_pop_data[j*IDX_W +: IDX_W];
                        end
                        r_scan_left <= i_pop_data[ORD_W +: CNT_W];
                        r_n         <= i_pop_data[ORD_W + CNT_W +: CNT_W];
                        r_elite     <= i_pop_data[ORD_W + 2 * CNT_W +: CNT_W];
                        r_bank      <= i_pop_data[JOB_W-1];
                        r_wr        <= '0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    for (int j = 0; j < MAX_POP - 1; j++) begin
                        r_ord[j] <= r_ord[j+1];
                    end
                    if (w_keep) begin
                        r_wr <= r_wr + CNT_W'(1);
                    end
                    r_scan_left <= r_scan_left - CNT_W'(1);
                    if (r_scan_left == CNT_W'(1)) begin
                        r_k     <= '0;
                        r_head  <= '0;
                        r_tail  <= CNT_W'(1);
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!w_stall) begin
                        r_k <= r_k + CNT_W'(1);
                        if (!w_elite_slot) begin
                            if (w_head_sum >= {1'b0, r_n}) begin
                                r_head <= CNT_W'(1);
                                r_tail <= '0;
                            end else begin
                                r_head <= w_head_sum[CNT_W-1:0];
                                r_tail <= r_tail + CNT_W'(2);
                            end
                        end
                        if (w_last_slot) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Rank table write: drop load indices beyond the population size
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_keep) begin
            r_rank_mem[r_wr[IDX_W-1:0]] <= r_ord[0];
        end
    end

    // Gene store write from the load side
    always_ff @(posedge i_clk) begin
        if (i_gene_we) begin
            r_gene_mem[i_gene_addr] <= i_gene_data;
        end
    end

    // Stage A: look up load indices of both parents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!w_stall) begin
            r_a_valid <= (r_state == ST_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_a_src_h <= r_rank_mem[w_hp[IDX_W-1:0]];
            r_a_src_t <= r_rank_mem[w_tp[IDX_W-1:0]];
            r_a_k     <= r_k;
            r_a_hp    <= w_hp;
            r_a_tp    <= w_tp;
            r_a_last  <= w_last_slot;
            r_a_bank  <= r_bank;
        end
    end

    // Stage B: fetch both parents' gene rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!w_stall) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_b_head_row <= r_gene_mem[{r_a_bank, r_a_src_h}];
            r_b_tail_row <= r_gene_mem[{r_a_bank, r_a_src_t}];
            r_b_k        <= r_a_k;
            r_b_hp       <= r_a_hp;
            r_b_tp       <= r_a_tp;
            r_b_last     <= r_a_last;
            r_b_bank     <= r_a_bank;
        end
    end

    // Output register: first half from head parent, second half from tail parent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_stall) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_out_slot <= SLOT_W'(r_b_k);
            r_out_a    <= r_b_head_row[0 +: GENE_BITS];
            r_out_b    <= r_b_head_row[GENE_BITS +: GENE_BITS];
            r_out_c    <= r_b_tail_row[2 * GENE_BITS +: GENE_BITS];
            r_out_d    <= r_b_tail_row[3 * GENE_BITS +: GENE_BITS];
            r_out_hp   <= RANK_W'(r_b_hp);
            r_out_tp   <= RANK_W'(r_b_tp);
            r_out_last <= r_b_last;
        end
    end

    // Hand the bank back once the last slot's genes are captured
    assign o_rel.valid = !w_stall && r_b_valid && r_b_last;
    assign o_rel.bank  = r_b_bank;

    assign o_result.valid            = r_out_valid;
    assign o_result.slot             = r_out_slot;
    assign o_result.child_a          = r_out_a;
    assign o_result.child_b          = r_out_b;
    assign o_result.child_c          = r_out_c;
    assign o_result.child_d          = r_out_d;
    assign o_result.head_parent_rank = r_out_hp;
    assign o_result.tail_parent_rank = r_out_tp;
    assign o_result.final_slot       = r_out_last;

endmodule

[design/population_rank_and_crossover.sv]
// Top level: population ranking with elitism and single-point crossover.
//
// Individuals (score and four gene words) arrive on i_item, one per transfer.
// After the population size is reached the batch is ranked by score, highest
// first with ties in load order, and the next generation leaves on o_result,
// one slot per transfer in slot order, final_slot marking the last one.
// The load side keeps a sorted row of scores updated on every load, so loading
// runs at one item per cycle while i_item.ready is high, and the ranking costs
// nothing extra there. Gene words sit in two banks: the next batch loads while the
// previous one drains. The emit side filters the sorted order into its rank table,
// one loaded item at a time, then streams one slot per cycle while the receiver is
// ready through a three-stage read pipeline (rank table, gene store, output
// register). It finishes scanning and emitting one batch before it takes the next.
// When the receiver stalls, the output register and pipeline hold; loading
// continues until both banks are full, then i_item.ready drops. Reset (synchronous,
// active low) empties the load count, the batch queue and the pipeline, and sets
// pop_count to 10 and elite_count to 2. Configuration writes go through i_cfg_we /
// i_cfg_idx / i_cfg_data, and the user must make them only while the block is idle;
// the block has no check of its own for this.
module population_rank_and_crossover #(
    parameter int MAX_POP   = 16,
    parameter int GENE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gaprc_in_if.sink                         i_item,
    gaprc_out_if.source                      o_result,
    input  logic                             i_cfg_we,
    input  logic [gaprc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gaprc_pkg::CFG_W-1:0]      i_cfg_data
);
    import gaprc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POP);
    localparam int CNT_W = $clog2(MAX_POP + 1);
    localparam int ORD_W = MAX_POP * IDX_W;
    localparam int JOB_W = ORD_W + 3 * CNT_W + 1;
    localparam int ROW_W = GENE_WORDS * GENE_BITS;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] TOP_POP = CMP_W'(MAX_POP - (MAX_POP % 2));

    logic [CFG_W-1:0] r_pop_count;
    logic [CFG_W-1:0] r_elite_count;
    logic [CMP_W-1:0] w_pop_ext;
    logic [CMP_W-1:0] w_elite_ext;
    logic [CNT_W-1:0] w_eff_pop;
    logic [CNT_W-1:0] w_eff_elite;

    logic             w_gene_we;
    logic [IDX_W:0]   w_gene_addr;
    logic [ROW_W-1:0] w_gene_data;
    logic             w_push_valid;
    logic             w_push_ready;
    logic [JOB_W-1:0] w_push_data;
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [JOB_W-1:0] w_pop_data;
    t_bank_rel        w_rel;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count   <= POP_RESET;
            r_elite_count <= ELITE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POP_COUNT:   r_pop_count   <= i_cfg_data;
                CFG_ELITE_COUNT: r_elite_count <= i_cfg_data;
            endcase
        end
    end

    // Effective size: drop the low bit, clamp to 2 .. even MAX_POP; clamp elite to it
    always_comb begin
        w_pop_ext = CMP_W'({r_pop_count[CFG_W-1:1], 1'b0});
        if (w_pop_ext < CMP_W'(2)) begin
            w_pop_ext = CMP_W'(2);
        end
        if (w_pop_ext > TOP_POP) begin
            w_pop_ext = TOP_POP;
        end
        w_elite_ext = CMP_W'(r_elite_count);
        if (w_elite_ext > w_pop_ext) begin
            w_elite_ext = w_pop_ext;
        end
        w_eff_pop   = CNT_W'(w_pop_ext);
        w_eff_elite = CNT_W'(w_elite_ext);
    end

    gaprc_front #(
        .MAX_POP   (MAX_POP),
        .GENE_BITS (GENE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_pop        (w_eff_pop),
        .i_elite      (w_eff_elite),
        .o_gene_we    (w_gene_we),
        .o_gene_addr  (w_gene_addr),
        .o_gene_data  (w_gene_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data),
        .i_rel        (w_rel)
    );

    gaprc_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    gaprc_back #(
        .MAX_POP   (MAX_POP),
        .GENE_BITS (GENE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gene_we   (w_gene_we),
        .i_gene_addr (w_gene_addr),
        .i_gene_data (w_gene_data),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_result    (o_result),
        .o_rel       (w_rel)
    );

    // Crossover parents always form a pair that differs only in the low rank bit
    a_pair_ranks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.head_parent_rank != o_result.tail_parent_rank))
        |-> ((o_result.head_parent_rank[3:1] == o_result.tail_parent_rank[3:1])
             && (o_result.head_parent_rank[0] != o_result.tail_parent_rank[0])))
        else $error("crossover parents are not a rank pair");

    // A bank is handed back only as the last slot of its batch enters the output
    a_rel_final : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rel.valid |=> (o_result.valid && o_result.final_slot))
        else $error("bank released without a final slot");

    // A finished batch is never posted to a full queue
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("batch posted to a full queue");

endmodule
